/* design/coau_pkg.sv */
// Package for the operand address unit: codes, phase type and item structs.
// Used by the interfaces and every design module; depends on nothing.
package coau_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned BYTE_W = 8;

  // Request type of an input item
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Addressing modes
  localparam logic [2:0] MODE_IMM     = 3'd0;
  localparam logic [2:0] MODE_ZP_IDX  = 3'd1;
  localparam logic [2:0] MODE_ABS_IDX = 3'd2;
  localparam logic [2:0] MODE_IND     = 3'd3;
  localparam logic [2:0] MODE_IDX_IND = 3'd4;
  localparam logic [2:0] MODE_IND_IDX = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_FINAL   = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  localparam logic [ADDR_W-1:0] PC_STEP_SHORT = 16'd2;
  localparam logic [ADDR_W-1:0] PC_STEP_LONG  = 16'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_LO,
    PH_WAIT_HI
  } phase_t;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        mode;
    logic [BYTE_W-1:0] operand_lo;
    logic [BYTE_W-1:0] operand_hi;
    logic [BYTE_W-1:0] index_value;
    logic [ADDR_W-1:0] pc_in;
    logic [BYTE_W-1:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] operand_value;
    logic [ADDR_W-1:0] next_pc;
    logic              page_crossed;
  } out_item_t;

  typedef struct packed {
    phase_t phase;
  } eng_status_t;

endpackage

/* design/coau_item_if.sv */
// Input channel: valid/ready handshake with the start or read-data item.
// Depends on coau_pkg.
interface coau_item_if
  import coau_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [2:0]        mode;
  logic [BYTE_W-1:0] operand_lo;
  logic [BYTE_W-1:0] operand_hi;
  logic [BYTE_W-1:0] index_value;
  logic [ADDR_W-1:0] pc_in;
  logic [BYTE_W-1:0] read_data;

  modport source (
    output valid, req_type, mode, operand_lo, operand_hi, index_value, pc_in, read_data,
    input  ready
  );
  modport sink (
    input  valid, req_type, mode, operand_lo, operand_hi, index_value, pc_in, read_data,
    output ready
  );
endinterface

/* design/coau_result_if.sv */
// Output channel: valid/ready handshake with one result item per transfer.
// Depends on coau_pkg.
interface coau_result_if
  import coau_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic [ADDR_W-1:0] read_address;
  logic [ADDR_W-1:0] operand_value;
  logic [ADDR_W-1:0] next_pc;
  logic              page_crossed;

  modport source (
    output valid, out_kind, read_address, operand_value, next_pc, page_crossed,
    input  ready
  );
  modport sink (
    input  valid, out_kind, read_address, operand_value, next_pc, page_crossed,
    output ready
  );
endinterface

/* design/cpu_operand_address_unit.sv */
// Top level of the operand address unit: input register, engine, result register.
// Depends on coau_pkg, coau_item_if, coau_result_if, coau_in_stage and coau_engine.
//
// Works out 6502-style operands. A start transfer (req_type 0) carries the mode,
// both operand bytes, the index and the opcode PC. Immediate, zero page + index
// and absolute + index answer straight away with the value or effective address,
// the advanced PC (+2, or +3 for absolute and indirect) and a page-crossed flag.
// The three indirect modes answer with a read request (out_kind 0); the caller
// then sends the byte read back as a req_type 1 transfer, gets the second read
// request, sends that byte, and receives the final result. Indirect keeps the
// original jump bug: a pointer at xxFF takes its high byte from xx00. Indexed
// indirect and the pointer of indirect indexed wrap within zero page. A start
// always drops any fetch in progress; an undefined mode, or a data transfer
// with no fetch pending, answers out_kind 2 and changes nothing else.
// Throughput is one transfer per clock while the sink stays ready. The item
// goes into the input register, then one pass through the engine logic lands
// it in the result register. Each item leaves the fetch phase for the next, so
// the phase register sits at the engine stage and updates as the item moves on.
// The result register holds a finished result while the sink stalls; input
// ready falls only when both registers are full and the sink is not ready.
module cpu_operand_address_unit
  import coau_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  coau_item_if.sink     item,
  coau_result_if.source result
);

  logic        in_valid;
  in_item_t    in_q;
  logic        advance;
  logic        step;
  out_item_t   eng_res;
  eng_status_t eng_status;
  logic        out_valid;
  out_item_t   out_q;

  // Pipe moves when the result slot is free or being emptied this cycle
  assign advance = !out_valid || result.ready;
  assign step    = in_valid && advance;

  coau_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .advance    (advance),
    .held_valid (in_valid),
    .held_item  (in_q)
  );

  coau_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .cur    (in_q),
    .res    (eng_res),
    .status (eng_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= eng_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.out_kind      = out_q.out_kind;
  assign result.read_address  = out_q.read_address;
  assign result.operand_value = out_q.operand_value;
  assign result.next_pc       = out_q.next_pc;
  assign result.page_crossed  = out_q.page_crossed;

`ifndef SYNTHESIS
  // A transfer taken at the input is held in the input register next cycle
  a_in_captured: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> in_valid)
    else $error("accepted item not held in input register");

  // A start never leaves the engine waiting for the high byte
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    step && in_q.req_type == REQ_START |=>
      eng_status.phase == PH_IDLE || eng_status.phase == PH_WAIT_LO)
    else $error("start item left engine in high-byte wait");

  // Low byte returned moves the fetch on to the high byte
  a_lo_to_hi: assert property (@(posedge clk) disable iff (rst)
    step && in_q.req_type == REQ_DATA && eng_status.phase == PH_WAIT_LO |=>
      eng_status.phase == PH_WAIT_HI)
    else $error("fetch did not advance after low byte");

  // Stray data with nothing pending leaves the engine idle
  a_stray_data: assert property (@(posedge clk) disable iff (rst)
    step && in_q.req_type == REQ_DATA && eng_status.phase == PH_IDLE |=>
      eng_status.phase == PH_IDLE && out_valid && out_q.out_kind == KIND_IGNORED)
    else $error("stray data item not ignored");
`endif

endmodule

/* design/coau_in_stage.sv */
// Input register of the operand address unit.
// Depends on coau_pkg and coau_item_if.
module coau_in_stage
  import coau_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  coau_item_if.sink      item,
  input  logic           advance,
  output logic           held_valid,
  output in_item_t       held_item
);

  assign item.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.ready) begin
      held_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_item.req_type    <= item.req_type;
      held_item.mode        <= item.mode;
      held_item.operand_lo  <= item.operand_lo;
      held_item.operand_hi  <= item.operand_hi;
      held_item.index_value <= item.index_value;
      held_item.pc_in       <= item.pc_in;
      held_item.read_data   <= item.read_data;
    end
  end

endmodule

/* design/coau_engine.sv */
// Addressing engine: fetch phase, held pointer context and the result logic.
// Depends on coau_pkg.
module coau_engine
  import coau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  in_item_t    cur,
  output out_item_t   res,
  output eng_status_t status
);

  phase_t            phase, phase_next;
  logic [2:0]        held_mode, held_mode_next;
  logic [ADDR_W-1:0] pointer_address, pointer_address_next;
  logic [BYTE_W-1:0] low_byte, low_byte_next;
  logic [BYTE_W-1:0] held_index, held_index_next;
  logic [ADDR_W-1:0] held_pc, held_pc_next;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] abs_ea;
  logic [BYTE_W-1:0] zp_ea;
  logic [ADDR_W-1:0] fetched;
  logic [ADDR_W-1:0] post_ea;
  logic [BYTE_W-1:0] ptr_hi_next;

  assign base    = {cur.operand_hi, cur.operand_lo};
  assign abs_ea  = base + {8'h00, cur.index_value};
  assign zp_ea   = cur.operand_lo + cur.index_value;
  assign fetched = {cur.read_data, low_byte};
  assign post_ea = fetched + {8'h00, held_index};
  // Only the low byte steps, so a pointer at xxFF wraps to xx00 (jump bug)
  assign ptr_hi_next = (held_mode == MODE_IND) ? pointer_address[15:8] : 8'h00;

  assign status.phase = phase;

  always_comb begin
    phase_next           = phase;
    held_mode_next       = held_mode;
    pointer_address_next = pointer_address;
    low_byte_next        = low_byte;
    held_index_next      = held_index;
    held_pc_next         = held_pc;
    res                  = '0;
    res.out_kind         = KIND_IGNORED;

    if (cur.req_type == REQ_START) begin
      phase_next = PH_IDLE;
      case (cur.mode)
        MODE_IMM: begin
          res.out_kind      = KIND_FINAL;
          res.operand_value = {8'h00, cur.operand_lo};
          res.next_pc       = cur.pc_in + PC_STEP_SHORT;
        end
        MODE_ZP_IDX: begin
          res.out_kind      = KIND_FINAL;
          res.operand_value = {8'h00, zp_ea};
          res.next_pc       = cur.pc_in + PC_STEP_SHORT;
        end
        MODE_ABS_IDX: begin
          res.out_kind      = KIND_FINAL;
          res.operand_value = abs_ea;
          res.next_pc       = cur.pc_in + PC_STEP_LONG;
          res.page_crossed  = (abs_ea[15:8] != cur.operand_hi);
        end
        MODE_IND, MODE_IDX_IND, MODE_IND_IDX: begin
          case (cur.mode)
            MODE_IND:     pointer_address_next = base;
            MODE_IDX_IND: pointer_address_next = {8'h00, zp_ea};
            default:      pointer_address_next = {8'h00, cur.operand_lo};
          endcase
          held_mode_next   = cur.mode;
          held_index_next  = cur.index_value;
          held_pc_next     = cur.pc_in;
          phase_next       = PH_WAIT_LO;
          res.out_kind     = KIND_READ;
          res.read_address = pointer_address_next;
        end
        default: begin
          res.out_kind = KIND_IGNORED;
        end
      endcase
    end else begin
      case (phase)
        PH_WAIT_LO: begin
          low_byte_next    = cur.read_data;
          phase_next       = PH_WAIT_HI;
          res.out_kind     = KIND_READ;
          res.read_address = {ptr_hi_next, pointer_address[7:0] + 8'd1};
        end
        PH_WAIT_HI: begin
          phase_next   = PH_IDLE;
          res.out_kind = KIND_FINAL;
          case (held_mode)
            MODE_IND: begin
              res.operand_value = fetched;
              res.next_pc       = held_pc + PC_STEP_LONG;
            end
            MODE_IDX_IND: begin
              res.operand_value = fetched;
              res.next_pc       = held_pc + PC_STEP_SHORT;
            end
            default: begin
              res.operand_value = post_ea;
              res.next_pc       = held_pc + PC_STEP_SHORT;
              res.page_crossed  = (post_ea[15:8] != cur.read_data);
            end
          endcase
        end
        default: begin
          phase_next   = PH_IDLE;
          res.out_kind = KIND_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      held_mode       <= '0;
      pointer_address <= '0;
      low_byte        <= '0;
      held_index      <= '0;
      held_pc         <= '0;
    end else if (step) begin
      phase           <= phase_next;
      held_mode       <= held_mode_next;
      pointer_address <= pointer_address_next;
      low_byte        <= low_byte_next;
      held_index      <= held_index_next;
      held_pc         <= held_pc_next;
    end
  end

endmodule
